>>> rtl/sfir_pkg.sv
// shared types and constants of the symmetric fir filter
package sfir_pkg;

  localparam int unsigned HalfW = 7;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqCoef   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDrain
  } state_e;

  typedef struct packed {
    logic start;
    logic tap_v;
    logic center;
  } mac_ctl_t;

endpackage

>>> rtl/sfir_mac.sv
// folded tap pair, multiply, saturating accumulate and output rounding
module sfir_mac #(
  parameter int COEF_WIDTH   = 24,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfir_pkg::mac_ctl_t             ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_l_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_r_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_i,
  output logic                           busy_o,
  output logic signed [SAMPLE_WIDTH-1:0] y_o,
  output logic                           clip_o
);

  localparam int PairW = SAMPLE_WIDTH + 1;
  localparam int ProdW = COEF_WIDTH + PairW;
  localparam int ExtW  = (ProdW > 64) ? ProdW : 64;
  localparam int Frac  = COEF_WIDTH - 2;
  localparam logic signed [63:0] Max64   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] Min64   = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] HalfLsb = 64'(1) << (Frac - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] OutMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OutMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] == s[63]) begin
      return s[63:0];
    end
    return s[64] ? Min64 : Max64;
  endfunction

  logic                     pr_v_q, mul_v_q;
  logic signed [PairW-1:0]  pair_d, pair_q;
  logic signed [COEF_WIDTH-1:0] coef_p_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ExtW-1:0]   prod_ext;
  logic signed [63:0]       prod64, acc_q, rnd, shifted;
  logic                     fits;

  // centre tap uses its sample once, other taps fold the mirrored pair
  assign pair_d = ctl_i.center ? PairW'(x_l_i) : PairW'(x_l_i) + PairW'(x_r_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      pr_v_q  <= ctl_i.tap_v;
      mul_v_q <= pr_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q   <= pair_d;
    coef_p_q <= coef_i;
    prod_q   <= coef_p_q * pair_q;
    if (ctl_i.start) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= sat_add64(acc_q, prod64);
    end
  end

  always_comb begin
    prod_ext = ExtW'(prod_q);
    if (&prod_ext[ExtW-1:63] || ~|prod_ext[ExtW-1:63]) begin
      prod64 = prod_ext[63:0];
    end else begin
      prod64 = prod_ext[ExtW-1] ? Min64 : Max64;
    end
  end

  // round half up, then clamp to the sample range
  always_comb begin
    rnd     = sat_add64(acc_q, HalfLsb);
    shifted = rnd >>> Frac;
    fits    = &shifted[63:SAMPLE_WIDTH-1] || ~|shifted[63:SAMPLE_WIDTH-1];
    if (fits) begin
      y_o = shifted[SAMPLE_WIDTH-1:0];
    end else begin
      y_o = shifted[63] ? OutMin : OutMax;
    end
    clip_o = !fits;
  end

  assign busy_o = pr_v_q | mul_v_q;

endmodule

>>> rtl/symmetric_fir_filter.sv
// top level of the symmetric linear-phase fir filter
// A sample item is written into a circular delay line of 2*MAX_HALF+1 entries held
// in a memory with two read ports; once the first half_len samples have passed, one
// shared multiplier walks the half_len+1 folded coefficients from a coefficient memory,
// one tap per cycle, so a sample that gives a result holds off the input until the
// result is loaded. Coefficient loads and warm-up samples never hold it off. The
// finished result sits in an output register, so the next item is taken while it
// waits. The delay line reads as zero until written, with no clearing pass.
module symmetric_fir_filter #(
  parameter int MAX_HALF     = 64,
  parameter int COEF_WIDTH   = 24,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  input  logic [sfir_pkg::HalfW-1:0]        coef_index_i,
  input  logic signed [COEF_WIDTH-1:0]      coef_value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfir_pkg::HalfW-1:0]        half_len_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    filtered_sample_o,
  output logic                              saturated_o
);

  localparam int Depth  = 2 * MAX_HALF + 1;
  localparam int LineAw = $clog2(Depth);
  localparam int TapAw  = $clog2(MAX_HALF + 1);
  localparam logic [LineAw-1:0] LastAddr = LineAw'(Depth - 1);
  localparam logic [LineAw-1:0] DepthA   = LineAw'(Depth);
  localparam logic [sfir_pkg::HalfW-1:0] HalfMax =
    (MAX_HALF > (2 ** sfir_pkg::HalfW - 1)) ? '1 : sfir_pkg::HalfW'(MAX_HALF);

  sfir_pkg::state_e state_q, state_d;

  logic [sfir_pkg::HalfW-1:0] half_len_q, warm_q;
  logic [LineAw-1:0]          wp_q, l_q, r_q, center, hl_line;
  logic [TapAw-1:0]           k_q, hl_tap;
  logic                       wrapped_q;
  logic                       in_fire, smp_fire, coef_we, coef_ok, warm_done, start;
  logic                       issue, last_tap, done_ok, out_load, mac_busy;
  logic                       rd_v_q, rd_ctr_q, l_ok_q, r_ok_q;
  logic                       out_valid_q, out_sat_q, mac_clip;

  logic signed [SAMPLE_WIDTH-1:0] line_mem [Depth];
  logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_HALF+1];
  logic signed [SAMPLE_WIDTH-1:0] rd_l_q, rd_r_q, x_l, x_r, out_data_q, mac_y;
  logic signed [COEF_WIDTH-1:0]   coef_rd_q;
  sfir_pkg::mac_ctl_t             mac_ctl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == sfir_pkg::StIdle);
  assign in_fire     = in_valid_i & in_ready_o;
  assign coef_ok     = (int'(coef_index_i) <= MAX_HALF);
  assign warm_done   = (warm_q >= half_len_q);
  assign hl_tap      = TapAw'(half_len_q);
  assign hl_line     = LineAw'(half_len_q);
  assign last_tap    = (k_q == hl_tap);
  assign done_ok     = !rd_v_q && !mac_busy && (!out_valid_q || out_ready_i);
  assign start       = smp_fire & warm_done;

  always_comb begin
    smp_fire = 1'b0;
    coef_we  = 1'b0;
    unique case (req_type_i)
      sfir_pkg::ReqSample: smp_fire = in_fire;
      sfir_pkg::ReqCoef:   coef_we  = in_fire & coef_ok;
      default: ;
    endcase
  end

  // centre sits half_len entries behind the newest sample
  assign center = wp_q - hl_line + ((wp_q < hl_line) ? DepthA : '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfir_pkg::StIdle:  if (start) state_d = sfir_pkg::StRun;
      sfir_pkg::StRun:   if (last_tap) state_d = sfir_pkg::StDrain;
      sfir_pkg::StDrain: if (done_ok) state_d = sfir_pkg::StIdle;
      default:           state_d = sfir_pkg::StIdle;
    endcase
  end

  always_comb begin
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      sfir_pkg::StIdle:  ;
      sfir_pkg::StRun:   issue = 1'b1;
      sfir_pkg::StDrain: out_load = done_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfir_pkg::StIdle;
      half_len_q  <= '0;
      warm_q      <= '0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      k_q         <= '0;
      l_q         <= '0;
      r_q         <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        half_len_q <= (half_len_i > HalfMax) ? HalfMax : half_len_i;
      end
      if (smp_fire) begin
        wp_q <= (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
        if (wp_q == LastAddr) begin
          wrapped_q <= 1'b1;
        end
        if (!warm_done) begin
          warm_q <= warm_q + 1'b1;
        end
      end
      if (start) begin
        k_q <= '0;
        l_q <= center;
        r_q <= center;
      end else if (issue) begin
        k_q <= k_q + 1'b1;
        l_q <= (l_q == '0) ? LastAddr : l_q - 1'b1;
        r_q <= (r_q == LastAddr) ? '0 : r_q + 1'b1;
      end
      rd_v_q      <= issue;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
    end
  end

  // delay line memory
  always_ff @(posedge clk_i) begin
    if (smp_fire) begin
      line_mem[wp_q] <= sample_i;
    end
    if (issue) begin
      rd_l_q   <= line_mem[l_q];
      rd_r_q   <= line_mem[r_q];
      l_ok_q   <= wrapped_q || (l_q < wp_q);
      r_ok_q   <= wrapped_q || (r_q < wp_q);
      rd_ctr_q <= (k_q == '0);
    end
  end

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[TapAw'(coef_index_i)] <= coef_value_i;
    end
    if (issue) begin
      coef_rd_q <= coef_mem[k_q];
    end
  end

  // entries not yet written read as zero
  assign x_l = l_ok_q ? rd_l_q : '0;
  assign x_r = r_ok_q ? rd_r_q : '0;

  assign mac_ctl = '{start: start, tap_v: rd_v_q, center: rd_ctr_q};

  sfir_mac #(
    .COEF_WIDTH   (COEF_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .x_l_i  (x_l),
    .x_r_i  (x_r),
    .coef_i (coef_rd_q),
    .busy_o (mac_busy),
    .y_o    (mac_y),
    .clip_o (mac_clip)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mac_y;
      out_sat_q  <= mac_clip;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;
  assign saturated_o       = out_sat_q;

endmodule
